### hdl/clsp_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the segment-against-plane clipper
// no dependencies; imported by every module of the block

package clsp_pkg;

	typedef enum logic [1:0] {
		ST_HIDDEN  = 2'd0,
		ST_TOUCH   = 2'd1,
		ST_VISIBLE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SIDE_ON    = 2'd0,
		SIDE_BACK  = 2'd1,
		SIDE_FRONT = 2'd2
	} side_t;

	// per-segment control decided by the front part
	typedef struct packed {
		status_t status;
		logic    cut;   // segment crosses the plane
		logic    swap;  // end point is the front one, so it becomes the start
	} seg_ctl_t;

	localparam int IDX_WIDTH = 3;

	localparam logic [IDX_WIDTH-1:0] REG_NORMAL_X = 3'd0;
	localparam logic [IDX_WIDTH-1:0] REG_NORMAL_Y = 3'd1;
	localparam logic [IDX_WIDTH-1:0] REG_NORMAL_Z = 3'd2;
	localparam logic [IDX_WIDTH-1:0] REG_PLANE_X  = 3'd3;
	localparam logic [IDX_WIDTH-1:0] REG_PLANE_Y  = 3'd4;
	localparam logic [IDX_WIDTH-1:0] REG_PLANE_Z  = 3'd5;
	localparam logic [IDX_WIDTH-1:0] REG_EPSILON  = 3'd6;

	localparam int EPS_RESET = 66;

endpackage

### hdl/clsp_front.sv
`timescale 1ns / 1ps
// front part: plane distances of both ends, side classification, status
// depends on clsp_pkg

module clsp_front #(
	parameter int CW = 32,
	parameter int FB = 16,
	localparam int MW = FB + CW + 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [CW-1:0]     p_in [3],
	input  logic signed [CW-1:0]     q_in [3],
	input  logic signed [FB+1:0]     nrm [3],
	input  logic signed [CW-1:0]     org [3],
	input  logic [FB:0]              eps,
	output logic                     push_valid,
	input  logic                     push_ready,
	output clsp_pkg::seg_ctl_t       ctl,
	output logic signed [CW-1:0]     p_out [3],
	output logic signed [CW-1:0]     q_out [3],
	output logic [MW-1:0]            num,
	output logic [MW-1:0]            den
);
	import clsp_pkg::*;

	localparam int DW  = CW + 1;
	localparam int PRW = FB + 2 + DW;
	localparam int PW  = PRW + 2;
	localparam int KW  = PW + 2 * FB + 1;

	logic fe;
	logic v_s1, v_s2, v_s3;
	logic signed [DW-1:0]  dp_s1 [3];
	logic signed [DW-1:0]  dq_s1 [3];
	logic signed [CW-1:0]  p_s1 [3], p_s2 [3], p_s3 [3];
	logic signed [CW-1:0]  q_s1 [3], q_s2 [3], q_s3 [3];
	logic signed [PRW-1:0] mp_s2 [3];
	logic signed [PRW-1:0] mq_s2 [3];
	logic signed [PW-1:0]  sp_s3, sq_s3;

	logic [PW-1:0]        mag_p, mag_q;
	logic [KW-1:0]        thr;
	side_t                side_p, side_q;
	logic signed [MW-1:0] dd;

	assign fe = !v_s3 || push_ready;
	assign in_ready = fe;
	assign push_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (fe) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			for (int i = 0; i < 3; i++) begin
				dp_s1[i] <= DW'(p_in[i]) - DW'(org[i]);
				dq_s1[i] <= DW'(q_in[i]) - DW'(org[i]);
				p_s1[i]  <= p_in[i];
				q_s1[i]  <= q_in[i];
				mp_s2[i] <= PRW'(nrm[i]) * PRW'(dp_s1[i]);
				mq_s2[i] <= PRW'(nrm[i]) * PRW'(dq_s1[i]);
				p_s2[i]  <= p_s1[i];
				q_s2[i]  <= q_s1[i];
				p_s3[i]  <= p_s2[i];
				q_s3[i]  <= q_s2[i];
			end
			sp_s3 <= PW'(mp_s2[0]) + PW'(mp_s2[1]) + PW'(mp_s2[2]);
			sq_s3 <= PW'(mq_s2[0]) + PW'(mq_s2[1]) + PW'(mq_s2[2]);
		end
	end

	always_comb begin
		mag_p = sp_s3[PW-1] ? PW'(-sp_s3) : PW'(sp_s3);
		mag_q = sq_s3[PW-1] ? PW'(-sq_s3) : PW'(sq_s3);
		thr = KW'(eps) << FB;
		if (KW'(mag_p) < thr)
			side_p = SIDE_ON;
		else if (sp_s3[PW-1])
			side_p = SIDE_BACK;
		else
			side_p = SIDE_FRONT;
		if (KW'(mag_q) < thr)
			side_q = SIDE_ON;
		else if (sq_s3[PW-1])
			side_q = SIDE_BACK;
		else
			side_q = SIDE_FRONT;

		// n.(Q-P) is exactly d(Q) - d(P)
		dd = MW'(sq_s3) - MW'(sp_s3);
		den = dd[MW-1] ? MW'(-dd) : MW'(dd);
		num = MW'(mag_p);

		ctl.cut  = (side_p == SIDE_FRONT && side_q == SIDE_BACK) ||
			(side_p == SIDE_BACK && side_q == SIDE_FRONT);
		ctl.swap = side_p == SIDE_BACK && side_q == SIDE_FRONT;
		if (side_p == SIDE_BACK && side_q == SIDE_BACK)
			ctl.status = ST_HIDDEN;
		else if ((side_p == SIDE_ON && side_q == SIDE_BACK) ||
			(side_p == SIDE_BACK && side_q == SIDE_ON))
			ctl.status = ST_TOUCH;
		else
			ctl.status = ST_VISIBLE;

		for (int i = 0; i < 3; i++) begin
			p_out[i] = p_s3[i];
			q_out[i] = q_s3[i];
		end
	end

endmodule

### hdl/clsp_fifo.sv
`timescale 1ns / 1ps
// short word queue between the front and back parts
// depends on clsp_pkg for nothing but house style; stand-alone storage

module clsp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	import clsp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNW-1:0]   count_q;
	logic             push, pop;

	assign wr_ready = count_q != CNW'(DEPTH);
	assign rd_valid = count_q != '0;
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + CNW'(1);
			else if (pop && !push)
				count_q <= count_q - CNW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNW'(DEPTH)) else $error("queue count beyond depth");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CNW'(1))
		else $error("queue count missed a push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

endmodule

### hdl/clsp_back.sv
`timescale 1ns / 1ps
// back part: pipelined fraction divider, cut point and output register
// depends on clsp_pkg

module clsp_back #(
	parameter int CW = 32,
	parameter int FB = 16,
	localparam int MW = FB + CW + 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  clsp_pkg::seg_ctl_t   ctl,
	input  logic signed [CW-1:0] p_in [3],
	input  logic signed [CW-1:0] q_in [3],
	input  logic [MW-1:0]        num,
	input  logic [MW-1:0]        den,
	output logic                 out_valid,
	input  logic                 out_ready,
	output clsp_pkg::status_t    status,
	output logic signed [CW-1:0] start_o [3],
	output logic signed [CW-1:0] end_o [3]
);
	import clsp_pkg::*;

	localparam int NS  = FB + 1;
	localparam int UW  = CW + 1;
	localparam int MLW = CW + FB + 2;
	localparam int RW  = CW + 2;
	localparam int SW  = CW + 3;

	logic be;

	// divider stages: index k holds the quotient after k fraction bits
	logic                 v_s [NS];
	logic [MW-1:0]        rem_s [NS];
	logic [MW-1:0]        den_s [NS];
	logic [FB:0]          quo_s [NS];
	logic                 zero_s [NS];
	seg_ctl_t             ctl_s [NS];
	logic signed [CW-1:0] p_s [NS][3];
	logic signed [CW-1:0] q_s [NS][3];

	logic                 v_sm, v_sr;
	logic [MLW-1:0]       m_sm [3];
	logic                 neg_sm [3], neg_sr [3];
	logic [RW-1:0]        mr_sr [3];
	seg_ctl_t             ctl_sm, ctl_sr;
	logic signed [CW-1:0] p_sm [3], q_sm [3], p_sr [3], q_sr [3];

	logic [MW-1:0]        r_init;
	logic [FB:0]          s_init;
	logic [FB:0]          s_eff;
	logic signed [UW-1:0] u [3];
	logic [UW-1:0]        umag [3];
	logic signed [SW-1:0] off [3];
	logic signed [SW-1:0] sum [3];
	logic signed [CW-1:0] cutp [3];

	assign be = !out_valid || out_ready;
	assign in_ready = be;

	always_comb begin
		r_init = num;
		s_init = '0;
		if (num >= den) begin
			s_init = (FB + 1)'(1);
			r_init = num - den;
		end
		if (r_init >= den)
			r_init = den - MW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++)
				v_s[k] <= 1'b0;
			v_sm <= 1'b0;
			v_sr <= 1'b0;
			out_valid <= 1'b0;
		end else if (be) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < NS; k++)
				v_s[k] <= v_s[k-1];
			v_sm <= v_s[NS-1];
			v_sr <= v_sm;
			out_valid <= v_sr;
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			rem_s[0]  <= r_init;
			den_s[0]  <= den;
			quo_s[0]  <= s_init;
			zero_s[0] <= den == '0;
			ctl_s[0]  <= ctl;
			p_s[0]    <= p_in;
			q_s[0]    <= q_in;
			// one quotient bit per stage; remainder stays below a nonzero divisor
			for (int k = 1; k < NS; k++) begin
				if ({rem_s[k-1], 1'b0} >= {1'b0, den_s[k-1]}) begin
					rem_s[k] <= MW'({rem_s[k-1], 1'b0} - {1'b0, den_s[k-1]});
					quo_s[k] <= {quo_s[k-1][FB-1:0], 1'b1};
				end else begin
					rem_s[k] <= {rem_s[k-1][MW-2:0], 1'b0};
					quo_s[k] <= {quo_s[k-1][FB-1:0], 1'b0};
				end
				den_s[k]  <= den_s[k-1];
				zero_s[k] <= zero_s[k-1];
				ctl_s[k]  <= ctl_s[k-1];
				p_s[k]    <= p_s[k-1];
				q_s[k]    <= q_s[k-1];
			end
		end
	end

	always_comb begin
		s_eff = zero_s[NS-1] ? '0 : quo_s[NS-1];
		for (int i = 0; i < 3; i++) begin
			u[i] = UW'(q_s[NS-1][i]) - UW'(p_s[NS-1][i]);
			umag[i] = u[i][UW-1] ? UW'(-u[i]) : UW'(u[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			for (int i = 0; i < 3; i++) begin
				m_sm[i]   <= MLW'(umag[i]) * MLW'(s_eff);
				neg_sm[i] <= u[i][UW-1];
				mr_sr[i]  <= RW'((m_sm[i] + (MLW'(1) << (FB - 1))) >> FB);
				neg_sr[i] <= neg_sm[i];
			end
			ctl_sm <= ctl_s[NS-1];
			p_sm   <= p_s[NS-1];
			q_sm   <= q_s[NS-1];
			ctl_sr <= ctl_sm;
			p_sr   <= p_sm;
			q_sr   <= q_sm;
		end
	end

	// offset is rounded half away from zero, then the sum saturates
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off[i] = SW'(mr_sr[i]);
			if (neg_sr[i])
				off[i] = -off[i];
			sum[i] = SW'(p_sr[i]) + off[i];
			if (sum[i] > SW'($signed({1'b0, {(CW - 1){1'b1}}})))
				cutp[i] = {1'b0, {(CW - 1){1'b1}}};
			else if (sum[i] < SW'($signed({1'b1, {(CW - 1){1'b0}}})))
				cutp[i] = {1'b1, {(CW - 1){1'b0}}};
			else
				cutp[i] = CW'(sum[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			status <= ctl_sr.status;
			for (int i = 0; i < 3; i++) begin
				if (ctl_sr.status != ST_VISIBLE) begin
					start_o[i] <= '0;
					end_o[i]   <= '0;
				end else begin
					start_o[i] <= ctl_sr.swap ? q_sr[i] : p_sr[i];
					end_o[i]   <= ctl_sr.cut ? cutp[i] : q_sr[i];
				end
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result word dropped while stalled");
	a_pipe_move: assert property (@(posedge clk) disable iff (!arst_n)
		(be && v_sr) |=> out_valid)
		else $error("round stage word did not reach output");
	a_swap_cut: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[0] && ctl_s[0].swap) |-> (ctl_s[0].cut && ctl_s[0].status == ST_VISIBLE))
		else $error("swap without a visible cut");

endmodule

### hdl/clip_segment_to_plane_top.sv
`timescale 1ns / 1ps
//  channel   | handshake              | word
//  input     | in_valid / in_ready    | start_in_x/y/z, end_in_x/y/z
//  output    | out_valid / out_ready  | status, start_out_x/y/z, end_out_x/y/z
//  config    | wr_en (no wait)        | wr_index, wr_data
// one segment a cycle unless a stage is stalled; the path runs through 3 front stages
// (differences, products, sums), the queue, FRAC_BITS + 1 divider stages, multiply,
// round and the output register. The divider pipeline sets the latency.
// arst_n clears valids, queue pointers and config registers to their reset values.
// the front stalls only on a full queue, the back only on a held output word.
// depends on clsp_pkg, clsp_front, clsp_fifo, clsp_back

module clip_segment_to_plane_top #(
	parameter int FRAC_BITS = 16,
	parameter int COORD_WIDTH = 32,
	localparam int DW = (COORD_WIDTH > FRAC_BITS + 2) ? COORD_WIDTH : FRAC_BITS + 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_WIDTH-1:0]       start_in_x,
	input  logic signed [COORD_WIDTH-1:0]       start_in_y,
	input  logic signed [COORD_WIDTH-1:0]       start_in_z,
	input  logic signed [COORD_WIDTH-1:0]       end_in_x,
	input  logic signed [COORD_WIDTH-1:0]       end_in_y,
	input  logic signed [COORD_WIDTH-1:0]       end_in_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic signed [COORD_WIDTH-1:0]       start_out_x,
	output logic signed [COORD_WIDTH-1:0]       start_out_y,
	output logic signed [COORD_WIDTH-1:0]       start_out_z,
	output logic signed [COORD_WIDTH-1:0]       end_out_x,
	output logic signed [COORD_WIDTH-1:0]       end_out_y,
	output logic signed [COORD_WIDTH-1:0]       end_out_z,
	input  logic                                wr_en,
	input  logic [clsp_pkg::IDX_WIDTH-1:0]      wr_index,
	input  logic [DW-1:0]                       wr_data
);
	import clsp_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int NW = FB + 2;
	localparam int EW = FB + 1;
	localparam int MW = FB + CW + 6;
	localparam int QW = $bits(seg_ctl_t) + 6 * CW + 2 * MW;
	localparam int QUEUE_DEPTH = 4;

	logic signed [NW-1:0] normal_q [3];
	logic signed [CW-1:0] plane_q [3];
	logic [EW-1:0]        eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_q[0] <= '0;
			normal_q[1] <= '0;
			normal_q[2] <= NW'(1) << FB;
			plane_q[0]  <= '0;
			plane_q[1]  <= '0;
			plane_q[2]  <= '0;
			eps_q       <= EW'(EPS_RESET);
		end else if (wr_en) begin
			case (wr_index)
				REG_NORMAL_X: normal_q[0] <= wr_data[NW-1:0];
				REG_NORMAL_Y: normal_q[1] <= wr_data[NW-1:0];
				REG_NORMAL_Z: normal_q[2] <= wr_data[NW-1:0];
				REG_PLANE_X:  plane_q[0]  <= wr_data[CW-1:0];
				REG_PLANE_Y:  plane_q[1]  <= wr_data[CW-1:0];
				REG_PLANE_Z:  plane_q[2]  <= wr_data[CW-1:0];
				REG_EPSILON:  eps_q       <= wr_data[EW-1:0];
				default: ;
			endcase
		end
	end

	logic signed [CW-1:0] p_w [3], q_w [3];
	assign p_w[0] = start_in_x;
	assign p_w[1] = start_in_y;
	assign p_w[2] = start_in_z;
	assign q_w[0] = end_in_x;
	assign q_w[1] = end_in_y;
	assign q_w[2] = end_in_z;

	logic                 f_valid, f_ready;
	seg_ctl_t             f_ctl;
	logic signed [CW-1:0] f_p [3], f_q [3];
	logic [MW-1:0]        f_num, f_den;

	clsp_front #(.CW(CW), .FB(FB)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.p_in(p_w), .q_in(q_w),
		.nrm(normal_q), .org(plane_q), .eps(eps_q),
		.push_valid(f_valid), .push_ready(f_ready),
		.ctl(f_ctl), .p_out(f_p), .q_out(f_q), .num(f_num), .den(f_den)
	);

	logic [QW-1:0]        wq, rq;
	logic                 b_valid, b_ready;
	seg_ctl_t             b_ctl;
	logic signed [CW-1:0] b_p [3], b_q [3];
	logic [MW-1:0]        b_num, b_den;

	assign wq = {f_ctl, f_p[0], f_p[1], f_p[2], f_q[0], f_q[1], f_q[2], f_num, f_den};
	assign {b_ctl, b_p[0], b_p[1], b_p[2], b_q[0], b_q[1], b_q[2], b_num, b_den} = rq;

	clsp_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(wq),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(rq)
	);

	status_t              st_w;
	logic signed [CW-1:0] so_w [3], eo_w [3];

	clsp_back #(.CW(CW), .FB(FB)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(b_valid), .in_ready(b_ready),
		.ctl(b_ctl), .p_in(b_p), .q_in(b_q), .num(b_num), .den(b_den),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(st_w), .start_o(so_w), .end_o(eo_w)
	);

	assign status      = st_w;
	assign start_out_x = so_w[0];
	assign start_out_y = so_w[1];
	assign start_out_z = so_w[2];
	assign end_out_x   = eo_w[0];
	assign end_out_y   = eo_w[1];
	assign end_out_z   = eo_w[2];

endmodule
